// File: design/dktc_pkg.sv
// Shared constants, types and codes for the compacting key table.
package dktc_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_BITS  = 48;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned KEY_BYTES = (KEY_BITS + 7) / 8;
  localparam int unsigned IN_DATA_W = 8 * KEY_BYTES;
  localparam int unsigned OUT_DATA_W = 8 * ((STAT_W + OUT_CNT_W + 7) / 8);
  localparam int unsigned APB_AW    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_idx_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                ins_en;
    logic                rem_en;
    logic [KEY_BITS-1:0] key;
    logic [CNT_W-1:0]    count;
  } cell_ctrl_t;

endpackage

// File: design/dktc_cell.sv
// One slot: loads a key on insert, compares it, takes its neighbor's on removal.
module dktc_cell (
  input  logic                          clk_i,
  input  dktc_pkg::cell_ctrl_t          ctrl_i,
  input  logic [dktc_pkg::IDX_W-1:0]    idx_i,
  input  logic                          hit_i,
  input  logic [dktc_pkg::KEY_BITS-1:0] next_key_i,
  output logic                          hit_o,
  output logic [dktc_pkg::KEY_BITS-1:0] key_o
);
  import dktc_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                valid;
  logic                is_tail;

  assign valid   = CNT_W'(idx_i) < ctrl_i.count;
  assign is_tail = CNT_W'(idx_i) == ctrl_i.count;
  // hit_o is set from the first matching slot onward
  assign hit_o   = hit_i | (valid & (key_q == ctrl_i.key));
  assign key_o   = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en && is_tail) begin
      key_d = ctrl_i.key;
    end else if (ctrl_i.rem_en && hit_o) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// File: design/dedup_key_table_compacting.sv
// Top level of the compacting deduplicating key table.
//
// Commands arrive on the s_axis word channel: tuser carries the mode
// (insert if absent / remove) and tdata the order key. Every command yields
// one result word on m_axis: status and the entry count after the command.
// The table is a row of DEPTH cells; a key is compared against all held
// entries and, on removal, later entries move down one slot, all in the
// cycle the command is accepted.
// The result is registered and is valid the cycle after acceptance.
// Throughput: one command per cycle; the output register takes the next
// result while the previous one is consumed in the same cycle.
// When the receiver stalls with a result pending, s_axis_tready drops until
// it is taken.
// Reset empties the table (count zero, key slots left as they are) and sets
// the capacity register to 16. The capacity register sits at APB byte
// address 0; write it only while the block is idle.
module dedup_key_table_compacting (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave command channel
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dktc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [47:0] order_key
  input  logic                             s_axis_tuser,  // [0] mode
  // master result channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dktc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [2:0] status, [7:3] entry_count
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dktc_pkg::APB_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dktc_pkg::*;

  logic [CAP_W-1:0]     cap_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [OUT_CNT_W-1:0] out_cnt_q;

  logic                 accept;
  logic                 reg_sel;
  logic                 full;
  logic                 hit_any;
  cell_ctrl_t           ctrl;
  logic [KEY_BITS-1:0]  in_key;
  mode_e                in_mode;

  logic                 hit_chain [DEPTH+1];
  logic [KEY_BITS-1:0]  cell_key  [DEPTH];

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_CAPACITY);
  assign prdata  = reg_sel ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // command decode
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_key        = s_axis_tdata[KEY_BITS-1:0];
  assign in_mode       = mode_e'(s_axis_tuser);

  assign full    = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q >= CNT_W'(DEPTH));
  assign hit_any = hit_chain[DEPTH];

  assign ctrl.key    = in_key;
  assign ctrl.count  = count_q;
  assign ctrl.ins_en = accept && (in_mode == MODE_INSERT) && !full && !hit_any;
  assign ctrl.rem_en = accept && (in_mode == MODE_REMOVE) && hit_any;

  // row of cells
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] next_key;
    if (i == DEPTH - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_mid
      assign next_key = cell_key[i+1];
    end
    dktc_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .idx_i      (IDX_W'(i)),
      .hit_i      (hit_chain[i]),
      .next_key_i (next_key),
      .hit_o      (hit_chain[i+1]),
      .key_o      (cell_key[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_ADDED;
    if (in_mode == MODE_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else if (hit_any) begin
        status_d = ST_DUP;
      end else begin
        status_d = ST_ADDED;
        count_d  = count_q + CNT_W'(1);
      end
    end else begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else if (hit_any) begin
        status_d = ST_REMOVED;
        count_d  = count_q - CNT_W'(1);
      end else begin
        status_d = ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_cnt_q <= OUT_CNT_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_cnt_q, status_q});

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count changed without a command");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("no result after an accepted command");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins_en && ctrl.rem_en))
    else $error("insert and remove enabled together");

endmodule
